>>> rtl/ppid_pkg.sv
// Shared types and constants of the positional PID controller.
package ppid_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN_P    = 2'd0,
    REG_GAIN_I    = 2'd1,
    REG_GAIN_D    = 2'd2,
    REG_INT_LIMIT = 2'd3
  } cfg_reg_t;

  localparam int SAMPLE_W = 16;   // setpoint and measured
  localparam int GAIN_W   = 16;   // signed gains
  localparam int LIMIT_W  = 30;   // integral magnitude bound
  localparam int ERR_W    = 17;   // setpoint - measured
  localparam int DERIV_W  = 18;   // error - previous error
  localparam int INTEG_W  = 31;   // clamped integral, |x| < 2**30
  localparam int DRIVE_W  = 32;   // saturated output
  localparam int ACC_W    = 48;   // exact weighted sum

  localparam logic signed [GAIN_W-1:0]  GAIN_P_RST    = 16'sd256;
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RST    = 16'sd0;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RST    = 16'sd0;
  localparam logic        [LIMIT_W-1:0] INT_LIMIT_RST = 30'h3FFF_FFFF;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

endpackage

>>> rtl/positional_pid_controller.sv
// Positional PID controller with integral clamp, top level.
//
// Each input item carries a setpoint and a measured value; the block returns one drive
// item per input: (kp*error + ki*integral + kd*derivative) >> GAIN_FRAC_BITS, truncated
// toward zero and saturated to signed 32 bits. The integral is clamped to
// +/- integral_limit after each error is added. The datapath is a five-register pipeline
// (error, integral/derivative update, products, sum, output); an accepted input moves
// through those registers in order, and one item is taken every cycle while the output
// is not stalled; the integral and previous-error registers close their loop in a single
// stage, which is what allows one item per cycle. Each stage advances whenever the stage
// after it is empty or moving, so empty stages fill while the output is stalled. The user must
// write gains and the limit through the cfg port while no item is in flight (not enforced).
module positional_pid_controller #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream. tdata: [15:0] setpoint, [31:16] measured.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,
  // Result stream. tdata: [31:0] drive.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  // Configuration write port.
  input  logic                       cfg_we,
  input  ppid_pkg::cfg_reg_t         cfg_addr,
  input  logic [ppid_pkg::LIMIT_W-1:0] cfg_wdata
);
  import ppid_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

  // Configuration registers.
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic        [LIMIT_W-1:0] int_limit_r;

  // Loop state.
  logic signed [INTEG_W-1:0] error_sum_r;
  logic signed [ERR_W-1:0]   prev_error_r;

  // Pipeline stage valids and payloads.
  logic                      s0_valid_r, s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic signed [ERR_W-1:0]   s0_err_r;
  logic signed [ERR_W-1:0]   s1_err_r;
  logic signed [INTEG_W-1:0] s1_integ_r;
  logic signed [DERIV_W-1:0] s1_deriv_r;
  logic signed [ERR_W+GAIN_W-1:0]   s2_prod_p_r;
  logic signed [INTEG_W+GAIN_W-1:0] s2_prod_i_r;
  logic signed [DERIV_W+GAIN_W-1:0] s2_prod_d_r;
  logic signed [ACC_W-1:0]   s3_acc_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic s0_rdy, s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic step_fire;

  logic signed [SAMPLE_W-1:0] setpoint, measured;
  logic signed [ERR_W-1:0]    err_nxt;
  logic signed [31:0]         sum_raw, lim_pos, lim_neg;
  logic signed [INTEG_W-1:0]  integ_nxt;
  logic signed [DERIV_W-1:0]  deriv_nxt;
  logic signed [ERR_W+GAIN_W-1:0]   prod_p_nxt;
  logic signed [INTEG_W+GAIN_W-1:0] prod_i_nxt;
  logic signed [DERIV_W+GAIN_W-1:0] prod_d_nxt;
  logic signed [ACC_W-1:0]   acc_nxt, acc_adj, acc_shr;
  logic                      acc_fits;
  logic signed [DRIVE_W-1:0] drive_nxt;

  // A stage can load when it is empty or its item moves on this cycle.
  assign out_rdy   = !out_valid_r || out_tready;
  assign s3_rdy    = !s3_valid_r || out_rdy;
  assign s2_rdy    = !s2_valid_r || s3_rdy;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign s0_rdy    = !s0_valid_r || s1_rdy;
  assign in_tready = s0_rdy;
  assign step_fire = s0_valid_r && s1_rdy;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  // Stage 0: error.
  assign setpoint = in_tdata[15:0];
  assign measured = in_tdata[31:16];
  assign err_nxt  = ERR_W'(setpoint) - ERR_W'(measured);

  // Stage 1: clamped integral and derivative.
  always_comb begin
    lim_pos = $signed({2'b00, int_limit_r});
    lim_neg = -lim_pos;
    sum_raw = 32'(error_sum_r) + 32'(s0_err_r);
    if (sum_raw > lim_pos) begin
      integ_nxt = INTEG_W'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      integ_nxt = INTEG_W'(lim_neg);
    end else begin
      integ_nxt = INTEG_W'(sum_raw);
    end
    deriv_nxt = DERIV_W'(s0_err_r) - DERIV_W'(prev_error_r);
  end

  // Stage 2: products.
  assign prod_p_nxt = (ERR_W+GAIN_W)'(gain_p_r) * (ERR_W+GAIN_W)'(s1_err_r);
  assign prod_i_nxt = (INTEG_W+GAIN_W)'(gain_i_r) * (INTEG_W+GAIN_W)'(s1_integ_r);
  assign prod_d_nxt = (DERIV_W+GAIN_W)'(gain_d_r) * (DERIV_W+GAIN_W)'(s1_deriv_r);

  // Stage 3: weighted sum.
  assign acc_nxt = ACC_W'(s2_prod_p_r) + ACC_W'(s2_prod_i_r) + ACC_W'(s2_prod_d_r);

  // Output: shift toward zero and saturate. A negative sum is biased up first so the
  // arithmetic shift truncates toward zero instead of toward minus infinity.
  always_comb begin
    acc_adj  = s3_acc_r[ACC_W-1] ? (s3_acc_r + ROUND_BIAS) : s3_acc_r;
    acc_shr  = acc_adj >>> GAIN_FRAC_BITS;
    acc_fits = (&acc_shr[ACC_W-1:DRIVE_W-1]) || !(|acc_shr[ACC_W-1:DRIVE_W-1]);
    if (acc_fits) begin
      drive_nxt = acc_shr[DRIVE_W-1:0];
    end else if (acc_shr[ACC_W-1]) begin
      drive_nxt = DRIVE_MIN;
    end else begin
      drive_nxt = DRIVE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      int_limit_r <= INT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:    gain_p_r    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_wdata[GAIN_W-1:0];
        REG_INT_LIMIT: int_limit_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      prev_error_r <= '0;
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (step_fire) begin
        error_sum_r  <= integ_nxt;
        prev_error_r <= s0_err_r;
      end
      if (s0_rdy)  s0_valid_r  <= in_tvalid;
      if (s1_rdy)  s1_valid_r  <= s0_valid_r;
      if (s2_rdy)  s2_valid_r  <= s1_valid_r;
      if (s3_rdy)  s3_valid_r  <= s2_valid_r;
      if (out_rdy) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_tvalid) begin
      s0_err_r <= err_nxt;
    end
    if (step_fire) begin
      s1_err_r   <= s0_err_r;
      s1_integ_r <= integ_nxt;
      s1_deriv_r <= deriv_nxt;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_prod_p_r <= prod_p_nxt;
      s2_prod_i_r <= prod_i_nxt;
      s2_prod_d_r <= prod_d_nxt;
    end
    if (s3_rdy && s2_valid_r) begin
      s3_acc_r <= acc_nxt;
    end
    if (out_rdy && s3_valid_r) begin
      drive_r <= drive_nxt;
    end
  end

  // After each step the stored integral lies within the limit that was in force.
  a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> (32'(error_sum_r) <= $past(lim_pos)) &&
                  (32'(error_sum_r) >= $past(lim_neg)))
    else $error("integral left the clamp range");

  // A stage-1 item that cannot move on is held unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_rdy) |=> s1_valid_r && $stable(s1_integ_r) && $stable(s1_err_r))
    else $error("stage 1 item lost while stalled");

  // The loop state only moves together with an item entering stage 1.
  a_state_moves_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    !step_fire |=> $stable(error_sum_r) && $stable(prev_error_r))
    else $error("loop state changed without an item");

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s0_valid_r)
    else $error("accepted item not captured");

endmodule

>>> tb/sv/tb_positional_pid_controller.sv
`timescale 1ns / 100ps
// Self-checking stream testbench of the positional PID controller with random idling.
module tb_positional_pid_controller;
  import ppid_pkg::*;

  localparam int FRAC_BITS     = 8;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 12;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;    // [15:0] setpoint, [31:16] measured
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;   // [31:0] drive
  logic                 cfg_we;
  cfg_reg_t             cfg_addr;
  logic [LIMIT_W-1:0]   cfg_wdata;

  // Mirror of the controller's registers and state.
  logic signed [GAIN_W-1:0]  kp_q;
  logic signed [GAIN_W-1:0]  ki_q;
  logic signed [GAIN_W-1:0]  kd_q;
  logic        [LIMIT_W-1:0] limit_q;
  logic signed [INTEG_W-1:0] integral_q;
  logic signed [ERR_W-1:0]   last_error_q;

  logic [DRIVE_W-1:0] pending_drives[$];
  logic [DRIVE_W-1:0] drive_want;
  int                 fails;
  int                 idle_cycles;
  int                 stall_left;
  bit                 feed_gaps;
  bit                 out_stalls;

  positional_pid_controller #(.GAIN_FRAC_BITS(FRAC_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Computes the drive for one sample and advances the integral and previous error.
  function automatic logic [DRIVE_W-1:0] pid_drive(input logic signed [SAMPLE_W-1:0] sp,
                                                   input logic signed [SAMPLE_W-1:0] ms);
    longint err;
    longint sum;
    longint lim;
    longint deriv;
    longint acc;
    longint res;
    err = longint'(sp) - longint'(ms);
    lim = 0;
    lim[LIMIT_W-1:0] = limit_q;
    sum = longint'(integral_q) + err;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    integral_q = sum[INTEG_W-1:0];
    deriv = err - longint'(last_error_q);
    last_error_q = err[ERR_W-1:0];
    acc = longint'(kp_q) * err + longint'(ki_q) * sum + longint'(kd_q) * deriv;
    // The magnitude is shifted, so negative sums truncate toward zero.
    res = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
    if (res > longint'(DRIVE_MAX)) res = longint'(DRIVE_MAX);
    if (res < longint'(DRIVE_MIN)) res = longint'(DRIVE_MIN);
    return res[DRIVE_W-1:0];
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int feed_gap();
    if (!feed_gaps || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return INT_LIMIT_RST;
      2: return LIMIT_W'($urandom_range(1, 2000));
      3: return LIMIT_W'($urandom_range(0, 1 << 20));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_extreme();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Offers one sample, waits for it to be taken and records the expected drive.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sp,
                             input logic signed [SAMPLE_W-1:0] ms);
    int gap;
    gap = feed_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ms, sp};
    do @(posedge clk); while (!in_tready);
    pending_drives.push_back(pid_drive(sp, ms));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:    kp_q = value[GAIN_W-1:0];
      REG_GAIN_I:    ki_q = value[GAIN_W-1:0];
      REG_GAIN_D:    kd_q = value[GAIN_W-1:0];
      REG_INT_LIMIT: limit_q = value;
      default: ;
    endcase
  endtask

  // Waits for the pipeline to empty, then writes all four registers.
  task automatic configure(input logic signed [GAIN_W-1:0] kp,
                           input logic signed [GAIN_W-1:0] ki,
                           input logic signed [GAIN_W-1:0] kd,
                           input logic [LIMIT_W-1:0] limit);
    drain();
    write_reg(REG_GAIN_P, LIMIT_W'(kp));
    write_reg(REG_GAIN_I, LIMIT_W'(ki));
    write_reg(REG_GAIN_D, LIMIT_W'(kd));
    write_reg(REG_INT_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  // Reset gains give drive equal to the error, including both error extremes.
  task automatic test_default_gains();
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'shFFFF, 16'sh0000);
    send_sample(16'sh0001, 16'sh0000);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // A gain of 1/256 exposes truncation toward zero on both signs.
  task automatic test_truncation();
    configure(16'sd1, 16'sd0, 16'sd0, INT_LIMIT_RST);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd257);
    send_sample(16'sd255, 16'sd0);
    send_sample(16'sd257, 16'sd0);
  endtask

  task automatic test_derivative();
    configure(16'sh8000, 16'sd0, 16'sh7FFF, INT_LIMIT_RST);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_integral_clamp();
    configure(16'sd0, 16'sd256, 16'sd0, 30'd1000);
    send_sample(16'sd600, 16'sd0);
    send_sample(16'sd600, 16'sd0);
    send_sample(16'sd600, 16'sd0);
    send_sample(16'sh8000, 16'sh7FFF);
    // A zero limit pins the integral at zero.
    configure(16'sd0, 16'sh7FFF, 16'sd0, 30'd0);
    send_sample(16'sh7FFF, 16'sh8000);
  endtask

  // Lowering the limit clamps the stored integral on the next sample.
  task automatic test_limit_lowered();
    configure(16'sd0, 16'sd256, 16'sd0, INT_LIMIT_RST);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    configure(16'sd0, 16'sd256, 16'sd0, 30'd50000);
    send_sample(16'sd0, 16'sd0);
  endtask

  // Random gains and limits with step-like runs; the first two phases wind the
  // integral up far enough to saturate the drive in both directions.
  task automatic test_random_traffic();
    int sent;
    int phase;
    int budget;
    int run;
    int mode;
    logic signed [SAMPLE_W-1:0] target;
    logic signed [SAMPLE_W-1:0] level;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      feed_gaps  = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      if (phase < 2) begin
        configure(rand_gain(), (phase == 0) ? 16'sh7FFF : 16'sh8000, rand_gain(), INT_LIMIT_RST);
        repeat ((phase == 0) ? 320 : 120) begin
          send_sample(16'sh7FFF - 16'($urandom_range(0, 63)),
                      16'sh8000 + 16'($urandom_range(0, 63)));
          sent++;
        end
      end else begin
        configure(rand_gain(), rand_gain(), rand_gain(), rand_limit());
        budget = $urandom_range(120, 260);
        while (budget > 0) begin
          mode = $urandom_range(0, 9);
          if (mode < 6) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(4, 40);
            target = 16'($urandom);
            level  = 16'($urandom);
            repeat (run) begin
              send_sample(target, level + 16'($urandom_range(0, 31)) - 16'sd16);
              sent++;
              budget--;
            end
          end else if (mode < 9) begin
            repeat ($urandom_range(1, 10)) begin
              send_sample(16'($urandom), 16'($urandom));
              sent++;
              budget--;
            end
          end else begin
            send_sample(rand_extreme(), rand_extreme());
            sent++;
            budget--;
          end
          if ($urandom_range(0, 19) == 0) drain();
        end
      end
      phase++;
    end
  endtask

  // Receiver: random stalls, some short and a few long.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stalls && $urandom_range(0, 99) < 25) begin
      stall_left <= idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drives.size() == 0) begin
        $error("drive: no item expected, actual %0d", $signed(out_tdata));
        fails++;
      end else begin
        drive_want = pending_drives.pop_front();
        if (out_tdata !== drive_want) begin
          $error("drive: expected %0d, actual %0d", $signed(drive_want), $signed(out_tdata));
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_GAIN_P;
    cfg_wdata    = '0;
    fails        = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    feed_gaps    = 1'b1;
    out_stalls   = 1'b1;
    kp_q         = GAIN_P_RST;
    ki_q         = GAIN_I_RST;
    kd_q         = GAIN_D_RST;
    limit_q      = INT_LIMIT_RST;
    integral_q   = '0;
    last_error_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_gains();
    test_truncation();
    test_derivative();
    test_integral_clamp();
    test_limit_lowered();
    test_random_traffic();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending_drives.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
